// ===== rtl/page_frame_refcount_allocator_unit_macros.svh =====
// Assertion macros shared by the page frame allocator RTL.
`ifndef PAGE_FRAME_REFCOUNT_ALLOCATOR_UNIT_MACROS_SVH
`define PAGE_FRAME_REFCOUNT_ALLOCATOR_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PFRA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define PFRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pfra_pkg.sv =====
// Types, codes and constants of the page frame allocator.
`default_nettype none

package pfra_pkg;

  // Defaults for the module parameters
  localparam int unsigned PAGE_COUNT_DEF   = 4096;
  localparam int unsigned BASE_ADDRESS_DEF = 32'h0010_0000;

  // Page geometry and counts
  localparam int unsigned PAGE_SHIFT = 12;
  localparam logic [7:0]  USED_COUNT = 8'd100;
  localparam logic [7:0]  MAX_COUNT  = 8'hFF;

  // Register reset values
  localparam logic [31:0] MAIN_START_RST = 32'h0030_0000;
  localparam logic [31:0] MEMORY_END_RST = 32'h0100_0000;

  // Register indexes (byte address / 4)
  localparam logic REG_MAIN_START = 1'b0;
  localparam logic REG_MEMORY_END = 1'b1;

  // Init range arithmetic widths: first page (signed), page count, index offset
  localparam int unsigned LO_W  = 22;
  localparam int unsigned CNT_W = 20;
  localparam int unsigned DK_W  = 23;

  // Status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NO_FREE      = 3'd1;
  localparam logic [2:0] ST_BELOW        = 3'd2;
  localparam logic [2:0] ST_NONEXIST     = 3'd3;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd4;
  localparam logic [2:0] ST_SATURATED    = 3'd5;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_SHARE = 2'd3
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] page_address;
  } cmd_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [2:0]  status;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/pfra_ram.sv =====
// Generic RAM: one write port, one read port with registered read data.
`default_nettype none

module pfra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/page_frame_refcount_allocator_unit.sv =====
// Page frame allocator: per-page reference counts in one RAM under a small sequencer.
//
// One command is taken at a time; cmd_stall stays high until its response is loaded
// into the output register. All work goes through the single count RAM (one write
// port, one registered read port): init rewrites every entry, then responds;
// allocate reads one entry per cycle from the top page down; free and share read,
// update and respond, or respond at once when the address is rejected.
// After reset a clearing pass sets every count to 100; no command is taken
// during it, while register writes are taken at any time.
`default_nettype none

module page_frame_refcount_allocator_unit
  import pfra_pkg::*;
#(
  parameter int unsigned PAGE_COUNT   = PAGE_COUNT_DEF,
  parameter int unsigned BASE_ADDRESS = BASE_ADDRESS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command channel
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire cmd_t        cmd,
  // response channel
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_t             rsp,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  `include "page_frame_refcount_allocator_unit_macros.svh"

  localparam int unsigned IDX_W = $clog2(PAGE_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAGE_COUNT - 1);
  localparam logic [31:0] BASE = 32'(BASE_ADDRESS);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SWEEP   = 6'b000010,
    S_SCAN    = 6'b000100,
    S_RMW_RD  = 6'b001000,
    S_RMW_UPD = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t             state;
  logic [31:0]        main_start;
  logic [31:0]        memory_end;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   chk_idx;
  logic               chk_valid;
  logic               report;
  op_t                cur_op;
  logic signed [LO_W-1:0] lo;
  logic [CNT_W-1:0]   cnt;
  logic [31:0]        res_addr;
  logic [2:0]         res_status;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;

  logic               cmd_fire;
  logic               cfg_wr;
  logic               rsp_free;
  logic               below;
  logic [31:0]        off;
  logic [31:0]        page_num;
  logic               past_map;
  logic               past_end;
  logic signed [33:0] start_off;
  logic signed [DK_W-1:0] dk;
  logic               in_range;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_fire  = cmd_valid && !cmd_stall;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign pready    = 1'b1;

  // Register read back
  always_comb begin
    case (paddr[2])
      REG_MAIN_START: prdata = main_start;
      REG_MEMORY_END: prdata = memory_end;
      default:        prdata = '0;
    endcase
  end

  // Address checks for free and share
  assign below     = cmd.page_address < BASE;
  assign off       = cmd.page_address - BASE;
  assign page_num  = off >> PAGE_SHIFT;
  assign past_map  = page_num >= 32'(PAGE_COUNT);
  assign past_end  = cmd.page_address >= memory_end;
  assign start_off = $signed({2'b00, main_start}) - $signed(34'(BASE));

  // Init range test for the swept index
  assign dk = $signed({{(DK_W-IDX_W){1'b0}}, idx}) - $signed({lo[LO_W-1], lo});
  assign in_range = !dk[DK_W-1] && (dk[DK_W-2:0] < {{(DK_W-1-CNT_W){1'b0}}, cnt});

  // Drive the count RAM write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = USED_COUNT;
    case (state)
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_wdata = in_range ? 8'd0 : USED_COUNT;
      end
      S_SCAN: begin
        ram_we    = chk_valid && (ram_rdata == 8'd0);
        ram_waddr = chk_idx;
        ram_wdata = 8'd1;
      end
      S_RMW_UPD: begin
        if (cur_op == OP_FREE) begin
          ram_we    = (ram_rdata != 8'd0);
          ram_wdata = ram_rdata - 8'd1;
        end else begin
          ram_we    = (ram_rdata != MAX_COUNT);
          ram_wdata = ram_rdata + 8'd1;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  pfra_ram #(
    .WIDTH(8),
    .DEPTH(PAGE_COUNT)
  ) u_counts (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  // Sequencer, registers and response
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      idx        <= '0;
      lo         <= '0;
      cnt        <= '0;
      report     <= 1'b0;
      chk_valid  <= 1'b0;
      rsp_valid  <= 1'b0;
      main_start <= MAIN_START_RST;
      memory_end <= MEMORY_END_RST;
    end else begin
      // Take register writes
      if (cfg_wr) begin
        case (paddr[2])
          REG_MAIN_START: main_start <= pwdata;
          REG_MEMORY_END: memory_end <= pwdata;
          default: ;
        endcase
      end

      // Drop the response once taken, unless the next one is loaded in its place
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            cur_op     <= cmd.operation;
            res_addr   <= '0;
            res_status <= ST_OK;
            case (cmd.operation)
              OP_INIT: begin
                lo     <= LO_W'(start_off >>> PAGE_SHIFT);
                cnt    <= (memory_end > main_start) ?
                          CNT_W'((memory_end - main_start) >> PAGE_SHIFT) : '0;
                idx    <= '0;
                report <= 1'b1;
                state  <= S_SWEEP;
              end
              OP_ALLOC: begin
                idx       <= LAST_IDX;
                chk_valid <= 1'b0;
                state     <= S_SCAN;
              end
              default: begin
                if (below) begin
                  res_status <= ST_BELOW;
                  state      <= S_DONE;
                end else if (past_map || (cmd.operation == OP_FREE && past_end)) begin
                  res_status <= ST_NONEXIST;
                  state      <= S_DONE;
                end else begin
                  idx   <= off[PAGE_SHIFT +: IDX_W];
                  state <= S_RMW_RD;
                end
              end
            endcase
          end
        end
        S_SWEEP: begin
          idx <= idx + 1'b1;
          if (idx == LAST_IDX) begin
            state <= report ? S_DONE : S_IDLE;
          end
        end
        S_SCAN: begin
          if (chk_valid && ram_rdata == 8'd0) begin
            res_addr <= BASE + ({{(32-IDX_W){1'b0}}, chk_idx} << PAGE_SHIFT);
            state    <= S_DONE;
          end else if (chk_valid && chk_idx == '0) begin
            res_status <= ST_NO_FREE;
            state      <= S_DONE;
          end else begin
            chk_idx   <= idx;
            chk_valid <= 1'b1;
            idx       <= idx - 1'b1;
          end
        end
        S_RMW_RD: begin
          state <= S_RMW_UPD;
        end
        S_RMW_UPD: begin
          if (cur_op == OP_FREE && ram_rdata == 8'd0) begin
            res_status <= ST_ALREADY_FREE;
          end else if (cur_op == OP_SHARE && ram_rdata == MAX_COUNT) begin
            res_status <= ST_SATURATED;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp_valid          <= 1'b1;
            rsp.result_address <= res_addr;
            rsp.status         <= res_status;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `PFRA_ASSERT_SAME(a_we_busy, ram_we, (state != S_IDLE) && (state != S_DONE),
    "count RAM written outside a working state")
  `PFRA_ASSERT_NEXT(a_cmd_busy, cmd_fire, state != S_IDLE,
    "sequencer idle right after taking a command")
  `PFRA_ASSERT_SAME(a_scan_order, (state == S_SCAN) && chk_valid,
    idx == IDX_W'(chk_idx - 1'b1), "scan read pointer out of step with check index")
  `PFRA_ASSERT_SAME(a_nofree_zero, rsp_valid && (rsp.status != ST_OK),
    rsp.result_address == 32'd0, "nonzero address returned with an error status")

endmodule

`default_nettype wire
